### hdl/linked_multi_queue_manager_defines.svh
// ----------------------------------------------------------------------------
// Linked multi-queue manager assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LINKED_MULTI_QUEUE_MANAGER_DEFINES_SVH
`define LINKED_MULTI_QUEUE_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define LMQM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LMQM_ASSERT_IMPLY(label, ante, cons, msg)
`define LMQM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hdl/lmqm_pkg.sv
// ----------------------------------------------------------------------------
// Linked multi-queue manager package
// Shared codes, defaults and types.
// ----------------------------------------------------------------------------
`default_nettype none

package lmqm_pkg;

  localparam int NUM_QUEUES_MAX_DEF = 16;
  localparam int POOL_ENTRIES_DEF   = 64;
  localparam int VALUE_BITS_DEF     = 32;

  localparam logic [4:0] NUM_QUEUES_RESET = 5'd16;

  // Request codes
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_LEAVE = 2'd1;
  localparam logic [1:0] FUNC_JOIN  = 2'd2;

  // Result codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_BADIDX = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_QUEUE,
    ST_RD_POOL
  } state_t;

  // Write enables of the queue table
  typedef struct packed {
    logic head;
    logic tail;
  } qt_we_t;

endpackage

`default_nettype wire

### hdl/linked_multi_queue_manager.sv
// ----------------------------------------------------------------------------
// Linked multi-queue manager
// FIFO queues kept as linked lists in one shared entry pool with a free list.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with func, queue_index, dest_index and item_value; the request
//   is taken at a clock edge where start is high and busy is low. func selects
//   add (append item_value), pop (remove the head) or join (splice the source
//   queue queue_index onto the tail of dest_index, leaving the source empty).
//   Every request gives exactly one result: done is high for one cycle with
//   status and popped_value; the receiver must take it in that cycle.
//   Each request walks a queue table read, a pool read (link and value at
//   the head or at the free-list head) and a write-back, after which done
//   is registered; busy stays high until then, and a new start is taken
//   while done is shown. num_queues is written through cfg_wr_en /
//   cfg_wr_data; the user must write it only while idle, as the block
//   does not enforce this. Reset empties every queue, marks all pool
//   entries unused and sets num_queues to 16. No clearing pass is needed:
//   pointers are only read behind the per-queue valid bits and the
//   fresh-entry count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linked_multi_queue_manager_defines.svh"

module linked_multi_queue_manager #(
  parameter int NUM_QUEUES_MAX = lmqm_pkg::NUM_QUEUES_MAX_DEF,
  parameter int POOL_ENTRIES   = lmqm_pkg::POOL_ENTRIES_DEF,
  parameter int VALUE_BITS     = lmqm_pkg::VALUE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire [1:0]                    func,
  input  wire [3:0]                    queue_index,
  input  wire [3:0]                    dest_index,
  input  wire signed [VALUE_BITS-1:0]  item_value,
  input  wire                          cfg_wr_en,
  input  wire [4:0]                    cfg_wr_data,
  output logic                         done,
  output logic [1:0]                   status,
  output logic signed [VALUE_BITS-1:0] popped_value
);

  localparam int QW = (NUM_QUEUES_MAX > 1) ? $clog2(NUM_QUEUES_MAX) : 1;
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);

  // Sequencer and latched request
  lmqm_pkg::state_t state, state_next;
  logic [1:0]                    op_func;
  logic [3:0]                    op_qa;
  logic [3:0]                    op_qb;
  logic signed [VALUE_BITS-1:0]  op_val;

  // Configuration and bookkeeping
  logic [4:0]                    num_queues;
  logic [NUM_QUEUES_MAX-1:0]     qnz;
  logic [PW-1:0]                 free_head;
  logic [CW-1:0]                 fresh_count;
  logic [CW-1:0]                 free_count;

  // Queue table
  logic [QW-1:0]                 qt_addr_a;
  logic [QW-1:0]                 qt_addr_b;
  logic [PW-1:0]                 head_a, tail_a, tail_b;
  lmqm_pkg::qt_we_t              qt_we;
  logic [QW-1:0]                 qt_waddr;
  logic [PW-1:0]                 qt_whead, qt_wtail;

  // Entry pool
  logic [PW-1:0]                 link_mem  [POOL_ENTRIES];
  logic [VALUE_BITS-1:0]         value_mem [POOL_ENTRIES];
  logic [PW-1:0]                 pool_raddr;
  logic [PW-1:0]                 link_rd;
  logic [VALUE_BITS-1:0]         value_rd;
  logic                          link_we;
  logic [PW-1:0]                 link_waddr, link_wdata;
  logic                          value_we;
  logic [PW-1:0]                 value_waddr;

  // Commit decisions
  logic                          accept;
  logic                          qa_ok, qb_ok, nz_a, nz_b, fresh_avail;
  logic [PW-1:0]                 new_e;
  logic                          alloc, release_e;
  logic                          set_nz, clr_nz;
  logic [QW-1:0]                 set_idx, clr_idx;
  logic [1:0]                    res_status;
  logic [VALUE_BITS-1:0]         res_popped;

  assign accept = start && !busy;

  // Hold the request address on the table while the request is in flight so
  // the read data stays valid through the write-back cycle.
  assign qt_addr_a = busy ? QW'(op_qa) : QW'(queue_index);
  assign qt_addr_b = busy ? QW'(op_qb) : QW'(dest_index);

  lmqm_qtable #(
    .NUM_QUEUES_MAX (NUM_QUEUES_MAX),
    .POOL_ENTRIES   (POOL_ENTRIES)
  ) u_qtable (
    .clk       (clk),
    .rd_addr_a (qt_addr_a),
    .rd_addr_b (qt_addr_b),
    .rd_head_a (head_a),
    .rd_tail_a (tail_a),
    .rd_tail_b (tail_b),
    .wr_en     (qt_we),
    .wr_addr   (qt_waddr),
    .wr_head   (qt_whead),
    .wr_tail   (qt_wtail)
  );

  // Pool read: a pop looks at its head entry, an add at the free-list head.
  assign pool_raddr = (op_func == lmqm_pkg::FUNC_LEAVE) ? head_a : free_head;

  always_ff @(posedge clk) begin
    if (state == lmqm_pkg::ST_RD_QUEUE) begin
      link_rd  <= link_mem[pool_raddr];
      value_rd <= value_mem[pool_raddr];
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (value_we) begin
      value_mem[value_waddr] <= op_val;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lmqm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lmqm_pkg::ST_RD_QUEUE;
        end
      end
      lmqm_pkg::ST_RD_QUEUE: state_next = lmqm_pkg::ST_RD_POOL;
      lmqm_pkg::ST_RD_POOL:  state_next = lmqm_pkg::ST_IDLE;
      default:               state_next = lmqm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy = (state != lmqm_pkg::ST_IDLE);
  end

  // Index checks and entry choice
  assign qa_ok = (int'(op_qa) < int'(num_queues)) && (int'(op_qa) < NUM_QUEUES_MAX);
  assign qb_ok = (int'(op_qb) < int'(num_queues)) && (int'(op_qb) < NUM_QUEUES_MAX);
  assign nz_a  = qnz[QW'(op_qa)];
  assign nz_b  = qnz[QW'(op_qb)];
  assign fresh_avail = (fresh_count < CW'(POOL_ENTRIES));
  assign new_e = fresh_avail ? PW'(fresh_count) : free_head;

  // Write-back: decide every memory and register update of the request.
  always_comb begin
    qt_we       = '0;
    qt_waddr    = QW'(op_qa);
    qt_whead    = new_e;
    qt_wtail    = new_e;
    link_we     = 1'b0;
    link_waddr  = tail_a;
    link_wdata  = new_e;
    value_we    = 1'b0;
    value_waddr = new_e;
    alloc       = 1'b0;
    release_e   = 1'b0;
    set_nz      = 1'b0;
    clr_nz      = 1'b0;
    set_idx     = QW'(op_qa);
    clr_idx     = QW'(op_qa);
    res_status  = lmqm_pkg::STATUS_OK;
    res_popped  = '0;
    if (state == lmqm_pkg::ST_RD_POOL) begin
      case (op_func)
        lmqm_pkg::FUNC_ADD: begin
          if (!qa_ok) begin
            res_status = lmqm_pkg::STATUS_BADIDX;
          end else if (free_count == '0) begin
            res_status = lmqm_pkg::STATUS_FULL;
          end else begin
            value_we = 1'b1;
            alloc    = 1'b1;
            if (nz_a) begin
              // Chain the old tail to the new entry.
              link_we     = 1'b1;
              qt_we.tail  = 1'b1;
            end else begin
              qt_we.head = 1'b1;
              qt_we.tail = 1'b1;
              set_nz     = 1'b1;
            end
          end
        end
        lmqm_pkg::FUNC_LEAVE: begin
          if (!qa_ok) begin
            res_status = lmqm_pkg::STATUS_BADIDX;
          end else if (!nz_a) begin
            res_status = lmqm_pkg::STATUS_EMPTY;
          end else begin
            res_popped = value_rd;
            if (head_a == tail_a) begin
              clr_nz = 1'b1;
            end else begin
              qt_we.head = 1'b1;
              qt_whead   = link_rd;
            end
            // Push the freed entry on the free list.
            link_we    = 1'b1;
            link_waddr = head_a;
            link_wdata = free_head;
            release_e  = 1'b1;
          end
        end
        lmqm_pkg::FUNC_JOIN: begin
          if (!qa_ok || !qb_ok) begin
            res_status = lmqm_pkg::STATUS_BADIDX;
          end else if ((op_qa != op_qb) && nz_a) begin
            qt_waddr   = QW'(op_qb);
            qt_we.tail = 1'b1;
            qt_wtail   = tail_a;
            if (nz_b) begin
              link_we    = 1'b1;
              link_waddr = tail_b;
              link_wdata = head_a;
            end else begin
              qt_we.head = 1'b1;
              qt_whead   = head_a;
              set_nz     = 1'b1;
              set_idx    = QW'(op_qb);
            end
            clr_nz = 1'b1;
          end
        end
        default: begin
          res_status = lmqm_pkg::STATUS_OK;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lmqm_pkg::ST_IDLE;
      num_queues  <= lmqm_pkg::NUM_QUEUES_RESET;
      qnz         <= '0;
      free_head   <= '0;
      fresh_count <= '0;
      free_count  <= CW'(POOL_ENTRIES);
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == lmqm_pkg::ST_RD_POOL);
      if (cfg_wr_en) begin
        num_queues <= cfg_wr_data;
      end
      if (clr_nz) begin
        qnz[clr_idx] <= 1'b0;
      end
      if (set_nz) begin
        qnz[set_idx] <= 1'b1;
      end
      if (alloc) begin
        free_count <= free_count - CW'(1);
        if (fresh_avail) begin
          fresh_count <= fresh_count + CW'(1);
        end else begin
          // Advance the free list past the entry just taken.
          free_head <= link_rd;
        end
      end
      if (release_e) begin
        free_count <= free_count + CW'(1);
        free_head  <= head_a;
      end
    end
  end

  // Latched request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func <= func;
      op_qa   <= queue_index;
      op_qb   <= dest_index;
      op_val  <= item_value;
    end
    if (state == lmqm_pkg::ST_RD_POOL) begin
      status       <= res_status;
      popped_value <= res_popped;
    end
  end

  // Checks
  `LMQM_ASSERT_NEXT(a_accept_to_lookup, accept, state == lmqm_pkg::ST_RD_QUEUE, "accepted request did not start lookup")
  `LMQM_ASSERT_NEXT(a_commit_strobe, state == lmqm_pkg::ST_RD_POOL, done && !busy, "write-back not followed by result strobe")
  `LMQM_ASSERT_IMPLY(a_pop_zero, done && (status != lmqm_pkg::STATUS_OK), popped_value == '0, "failed request returned a value")
  `LMQM_ASSERT_IMPLY(a_pool_count, 1'b1, (int'(free_count) + int'(fresh_count)) >= POOL_ENTRIES, "free count below unused entries")

endmodule

`default_nettype wire

### hdl/lmqm_qtable.sv
// ----------------------------------------------------------------------------
// Queue table
// Head and tail pointer memories, two registered read ports, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lmqm_qtable #(
  parameter int NUM_QUEUES_MAX = lmqm_pkg::NUM_QUEUES_MAX_DEF,
  parameter int POOL_ENTRIES   = lmqm_pkg::POOL_ENTRIES_DEF,
  localparam int QW = (NUM_QUEUES_MAX > 1) ? $clog2(NUM_QUEUES_MAX) : 1,
  localparam int PW = $clog2(POOL_ENTRIES)
) (
  input  wire                    clk,
  input  wire [QW-1:0]           rd_addr_a,
  input  wire [QW-1:0]           rd_addr_b,
  output logic [PW-1:0]          rd_head_a,
  output logic [PW-1:0]          rd_tail_a,
  output logic [PW-1:0]          rd_tail_b,
  input  wire lmqm_pkg::qt_we_t  wr_en,
  input  wire [QW-1:0]           wr_addr,
  input  wire [PW-1:0]           wr_head,
  input  wire [PW-1:0]           wr_tail
);

  logic [PW-1:0] head_mem [NUM_QUEUES_MAX];
  logic [PW-1:0] tail_mem [NUM_QUEUES_MAX];

  always_ff @(posedge clk) begin
    if (wr_en.head) begin
      head_mem[wr_addr] <= wr_head;
    end
    if (wr_en.tail) begin
      tail_mem[wr_addr] <= wr_tail;
    end
    rd_head_a <= head_mem[rd_addr_a];
    rd_tail_a <= tail_mem[rd_addr_a];
    rd_tail_b <= tail_mem[rd_addr_b];
  end

endmodule

`default_nettype wire
